/* rtl/gmm_pkg.sv */
// gmm_pkg: shared constants, register map and types for the 3x3 gray morphology unit
// no dependencies; imported by every other file of the block

package gmm_pkg;

  localparam int GMM_MAX_WIDTH  = 2048;
  localparam int GMM_MAX_HEIGHT = 2048;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 12;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;
  localparam int WIN_TAPS   = 9;
  localparam int WIN_CENTER = 4;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MORPH_MODE   = 2'd2;

  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hff;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'h00;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             morph_mode;
  } gmm_cfg_t;

  // one request after the counter stage; nb_valid is indexed column * 3 + row
  typedef struct packed {
    logic                emit;
    logic                eof;
    logic [WIN_TAPS-1:0] nb_valid;
    logic [PIX_W-1:0]    pix;
  } gmm_item_t;

endpackage

/* rtl/gmm_if.sv */
// valid/ready stream interfaces for pixel requests and result requests
// depends on gmm_pkg

interface gmm_pix_if;
  import gmm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             drain;

  modport source (output valid, pixel_value, drain, input ready);
  modport sink   (input valid, pixel_value, drain, output ready);
endinterface

interface gmm_res_if;
  import gmm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_value;
  logic             end_of_frame;

  modport source (output valid, out_value, end_of_frame, input ready);
  modport sink   (input valid, out_value, end_of_frame, output ready);
endinterface

/* rtl/gmm_regs.sv */
// gmm_regs: APB register file holding frame size and morphology mode
// depends on gmm_pkg; raises restart when a frame dimension is written

module gmm_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gmm_pkg::APB_AW-1:0]   paddr,
  input  logic [gmm_pkg::APB_DW-1:0]   pwdata,
  output logic [gmm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output gmm_pkg::gmm_cfg_t            cfg,
  output logic                         restart
);
  import gmm_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready  = 1'b1;
  assign idx     = paddr[APB_AW-1:2];
  assign wr      = psel && penable && pwrite && pready;
  assign restart = wr && ((idx == REG_FRAME_WIDTH) || (idx == REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= FRAME_WIDTH_RST;
      cfg.frame_height <= FRAME_HEIGHT_RST;
      cfg.morph_mode   <= MODE_ERODE;
    end else if (wr) begin
      case (idx)
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[DIM_W-1:0];
        REG_MORPH_MODE:   cfg.morph_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DW'(cfg.frame_height);
      REG_MORPH_MODE:   prdata = APB_DW'(cfg.morph_mode);
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/gmm_front.sv */
// gmm_front: raster counters, request classification and the stage register
// depends on gmm_pkg; drives the line store read port

module gmm_front #(
  parameter  int MAX_WIDTH  = gmm_pkg::GMM_MAX_WIDTH,
  parameter  int MAX_HEIGHT = gmm_pkg::GMM_MAX_HEIGHT,
  localparam int CW         = $clog2(MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gmm_pkg::gmm_cfg_t          cfg,
  input  logic                       restart,
  input  logic                       in_valid,
  input  logic [gmm_pkg::PIX_W-1:0]  in_pixel,
  input  logic                       in_drain,
  output logic                       in_ready,
  input  logic                       s1_adv,
  output logic                       s1_valid,
  output gmm_pkg::gmm_item_t         s1_item,
  output logic [CW-1:0]              s1_col,
  output logic                       rd_en,
  output logic [CW-1:0]              rd_addr
);
  import gmm_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int IRW = $clog2(MAX_HEIGHT + 3);

  logic [CW-1:0]  in_col;
  logic [IRW-1:0] in_row;
  logic [CW-1:0]  out_col;
  logic [HW-1:0]  out_row;

  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic           accept, frame_in, skip, take, primed, emit, eof;
  logic [WW-1:0]  col_inc, oc_inc;
  logic [HW-1:0]  orow_inc;
  logic           in_wrap, last_col, last_row;
  logic           left, right, top, bottom;
  gmm_item_t      item;

  // zero means one, oversize saturates
  always_comb begin
    if (cfg.frame_width == '0) w_eff = WW'(1);
    else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg.frame_width);
    if (cfg.frame_height == '0) h_eff = HW'(1);
    else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(cfg.frame_height);
  end

  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;
  assign frame_in = in_row >= IRW'(h_eff);
  // drain before the frame is complete is dropped
  assign skip     = in_drain && !frame_in;
  assign take     = accept && !skip;

  assign primed   = (in_row >= IRW'(2)) || ((in_row == IRW'(1)) && (in_col != '0));
  assign emit     = primed && (out_row < h_eff);

  assign col_inc  = WW'(in_col) + WW'(1);
  assign in_wrap  = col_inc >= w_eff;
  assign oc_inc   = WW'(out_col) + WW'(1);
  assign last_col = oc_inc >= w_eff;
  assign orow_inc = out_row + HW'(1);
  assign last_row = orow_inc >= h_eff;
  assign eof      = emit && last_col && last_row;

  assign left   = out_col != '0;
  assign right  = !last_col;
  assign top    = out_row != '0;
  assign bottom = !last_row;

  always_comb begin
    item.emit     = emit;
    item.eof      = eof;
    item.nb_valid = {right & bottom, right, right & top,
                     bottom, 1'b0, top,
                     left & bottom, left, left & top};
    item.pix      = frame_in ? PIX_MIN : in_pixel;
  end

  assign rd_en   = take;
  assign rd_addr = in_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (restart || (take && eof)) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else if (take) begin
        if (in_wrap) begin
          in_col <= '0;
          in_row <= in_row + IRW'(1);
        end else begin
          in_col <= col_inc[CW-1:0];
        end
        if (emit) begin
          if (last_col) begin
            out_col <= '0;
            out_row <= orow_inc;
          end else begin
            out_col <= oc_inc[CW-1:0];
          end
        end
      end
      if (take) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item <= item;
      s1_col  <= in_col;
    end
  end

endmodule

/* rtl/gmm_line_store.sv */
// gmm_line_store: two line buffers packed as one memory word {upper, middle}
// depends on gmm_pkg; registered read with write-through for a same-address write

module gmm_line_store #(
  parameter  int MAX_WIDTH = gmm_pkg::GMM_MAX_WIDTH,
  localparam int CW        = $clog2(MAX_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [CW-1:0]                rd_addr,
  output logic [2*gmm_pkg::PIX_W-1:0]  rd_data,
  input  logic                         wr_en,
  input  logic [CW-1:0]                wr_addr,
  input  logic [2*gmm_pkg::PIX_W-1:0]  wr_data
);
  import gmm_pkg::*;

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      // one-pixel lines hit the entry being written back
      if (wr_en && (wr_addr == rd_addr)) rd_data <= wr_data;
      else rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/gmm_window.sv */
// gmm_window: 3x3 window shift, masked neighbour min/max and the result register
// depends on gmm_pkg; takes line store data and the stage register from gmm_front

module gmm_window (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s1_valid,
  input  gmm_pkg::gmm_item_t           s1_item,
  input  logic [2*gmm_pkg::PIX_W-1:0]  line_data,
  input  logic                         morph_mode,
  output logic                         s1_adv,
  output logic [2*gmm_pkg::PIX_W-1:0]  wr_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [gmm_pkg::PIX_W-1:0]    out_value,
  output logic                         out_eof
);
  import gmm_pkg::*;

  logic [PIX_W-1:0] win      [WIN_TAPS];
  logic [PIX_W-1:0] win_next [WIN_TAPS];
  logic [PIX_W-1:0] up, mid, acc;

  assign up  = line_data[2*PIX_W-1:PIX_W];
  assign mid = line_data[PIX_W-1:0];

  // upper takes the old middle, middle takes the new pixel
  assign wr_data = {mid, s1_item.pix};
  assign s1_adv  = s1_valid && (!s1_item.emit || !out_valid || out_ready);

  always_comb begin
    for (int k = 0; k < WIN_TAPS - 3; k++) win_next[k] = win[k+3];
    win_next[WIN_TAPS-3] = up;
    win_next[WIN_TAPS-2] = mid;
    win_next[WIN_TAPS-1] = s1_item.pix;
  end

  always_comb begin
    acc = (morph_mode == MODE_DILATE) ? PIX_MIN : PIX_MAX;
    for (int k = 0; k < WIN_TAPS; k++) begin
      if (s1_item.nb_valid[k] && (k != WIN_CENTER)) begin
        if (morph_mode == MODE_DILATE) begin
          if (win_next[k] > acc) acc = win_next[k];
        end else begin
          if (win_next[k] < acc) acc = win_next[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int k = 0; k < WIN_TAPS; k++) win[k] <= PIX_MIN;
    end else begin
      if (s1_adv) begin
        for (int k = 0; k < WIN_TAPS; k++) win[k] <= win_next[k];
      end
      if (s1_adv && s1_item.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item.emit) begin
      out_value <= acc;
      out_eof   <= s1_item.eof;
    end
  end

endmodule

/* rtl/gray_morph_3x3_min_max_unit.sv */
// gray_morph_3x3_min_max_unit: top level of the 3x3 gray erosion/dilation block
// depends on gmm_pkg, gmm_if, gmm_regs, gmm_front, gmm_line_store, gmm_window

// Takes one 8-bit pixel per clock in raster order, while the result side does
// not stall, and returns, per pixel, the minimum (erode) or maximum (dilate)
// of its in-frame 3x3 neighbours, centre excluded; with no neighbour the
// result is 255 for erode and 0 for dilate. Sustained rate is one request per
// clock on both sides while the receiver keeps ready high; the stage register
// and the line store read, loaded together, feed the output register. Results lag
// the pixel stream by frame_width+1 requests, so after each frame send
// frame_width+1 drain requests; drains arriving before the frame is complete
// are dropped. Writing frame_width or frame_height restarts the frame. The line
// stores need no clearing after reset. Registers: 0x0 frame_width, 0x4
// frame_height, 0x8 morph_mode (0 erode, 1 dilate); write only while idle.

module gray_morph_3x3_min_max_unit #(
  parameter int MAX_WIDTH  = gmm_pkg::GMM_MAX_WIDTH,
  parameter int MAX_HEIGHT = gmm_pkg::GMM_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  gmm_pix_if.sink                     pixel_ch,
  gmm_res_if.source                   result_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gmm_pkg::APB_AW-1:0]  paddr,
  input  logic [gmm_pkg::APB_DW-1:0]  pwdata,
  output logic [gmm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import gmm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  gmm_cfg_t           cfg;
  logic               restart;
  logic               s1_adv, s1_valid;
  gmm_item_t          s1_item;
  logic [CW-1:0]      s1_col;
  logic               rd_en;
  logic [CW-1:0]      rd_addr;
  logic [2*PIX_W-1:0] line_data, wr_data;

  gmm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  gmm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .restart  (restart),
    .in_valid (pixel_ch.valid),
    .in_pixel (pixel_ch.pixel_value),
    .in_drain (pixel_ch.drain),
    .in_ready (pixel_ch.ready),
    .s1_adv   (s1_adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_col   (s1_col),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr)
  );

  gmm_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (line_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  gmm_window u_window (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .line_data  (line_data),
    .morph_mode (cfg.morph_mode),
    .s1_adv     (s1_adv),
    .wr_data    (wr_data),
    .out_ready  (result_ch.ready),
    .out_valid  (result_ch.valid),
    .out_value  (result_ch.out_value),
    .out_eof    (result_ch.end_of_frame)
  );

endmodule

/* rtl/gmm_checker.sv */
// gmm_checker: port-level assertions for the 3x3 gray morphology unit
// depends on gmm_pkg; bound to gray_morph_3x3_min_max_unit below

module gmm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gmm_pkg::PIX_W-1:0]   out_value,
  input logic                        out_eof,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [gmm_pkg::APB_AW-1:0]  paddr,
  input logic [gmm_pkg::APB_DW-1:0]  pwdata,
  input logic [gmm_pkg::APB_DW-1:0]  prdata
);
  import gmm_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_eof))
    else $error("result changed while stalled");

  // with the output register empty nothing may block the pixel side
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pixel side stalled with empty output register");

  // frame width reads back what was written
  a_width_rb: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_FRAME_WIDTH))
    ##1 (psel && !pwrite && (paddr[APB_AW-1:2] == REG_FRAME_WIDTH))
    |-> prdata[DIM_W-1:0] == $past(pwdata[DIM_W-1:0]))
    else $error("frame_width readback mismatch");

endmodule

bind gray_morph_3x3_min_max_unit gmm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pixel_ch.ready),
  .out_valid (result_ch.valid),
  .out_ready (result_ch.ready),
  .out_value (result_ch.out_value),
  .out_eof   (result_ch.end_of_frame),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

/* verif/tb_gray_morph_3x3_min_max_unit.sv */
// testbench for gray_morph_3x3_min_max_unit: streams pixel requests, predicts every
// neighbour min/max result in step with the block and compares each one field by field
// depends on gmm_pkg, gmm_if and the rtl of gray_morph_3x3_min_max_unit

module tb_gray_morph_3x3_min_max_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gmm_pkg::*;

  localparam int          SETTLE_CYCLES = 8;
  localparam int          RANDOM_ITEMS  = 900;
  localparam int          HOLD_CYCLES   = 300;
  localparam longint      TIMEOUT_NS    = 64'd10_000_000;
  localparam logic [1:0]  REG_UNMAPPED  = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             drain;
  } pix_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             eof;
  } morph_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic             pix_valid = 1'b0;
  logic [PIX_W-1:0] pix_value = '0;
  logic             pix_drain = 1'b0;
  logic             res_ready = 1'b0;

  gmm_pix_if pixel_ch ();
  gmm_res_if result_ch ();

  assign pixel_ch.valid       = pix_valid;
  assign pixel_ch.pixel_value = pix_value;
  assign pixel_ch.drain       = pix_drain;
  assign result_ch.ready      = res_ready;

  gray_morph_3x3_min_max_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_ch  (pixel_ch),
    .result_ch (result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial forever #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state
  logic [DIM_W-1:0] cfg_width  = FRAME_WIDTH_RST;
  logic [DIM_W-1:0] cfg_height = FRAME_HEIGHT_RST;
  logic             cfg_mode   = MODE_ERODE;

  bit [PIX_W-1:0] line_up  [GMM_MAX_WIDTH];
  bit [PIX_W-1:0] line_mid [GMM_MAX_WIDTH];
  bit [PIX_W-1:0] taps     [WIN_TAPS];
  int unsigned    in_col, in_row, out_col, out_row;

  pix_req_t   pixel_queue [$];
  morph_res_t morph_due [$];

  int mismatches  = 0;
  int frame_items = 0;
  int tx_gap_max  = 0;
  int rx_stall_max = 0;
  int hold_req    = 0;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] raw, int unsigned lim);
    int unsigned r;
    r = 32'(raw);
    if (r == 0) return 1;
    if (r > lim) return lim;
    return r;
  endfunction

  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // advances the model by one accepted request, queues the result it produces
  function automatic void neighbour_min_max(pix_req_t req);
    int unsigned w, h, col;
    int          dc, dr, k;
    bit          past_frame, primed;
    bit [PIX_W-1:0] pix, up, mid, acc, v;
    morph_res_t  res;
    w = clamp_dim(cfg_width, GMM_MAX_WIDTH);
    h = clamp_dim(cfg_height, GMM_MAX_HEIGHT);
    past_frame = (in_row >= h);
    // drain before the frame is complete is dropped
    if (req.drain && !past_frame) return;
    pix = past_frame ? PIX_MIN : req.pixel;
    primed = (in_row >= 2) || (in_row == 1 && in_col >= 1);

    col = (in_col >= GMM_MAX_WIDTH) ? GMM_MAX_WIDTH - 1 : in_col;
    up  = line_up[col];
    mid = line_mid[col];
    line_up[col]  = mid;
    line_mid[col] = pix;
    for (k = 0; k < 6; k++) taps[k] = taps[k + 3];
    taps[6] = up;
    taps[7] = mid;
    taps[8] = pix;

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!primed || out_row >= h) return;

    acc = (cfg_mode == MODE_DILATE) ? PIX_MIN : PIX_MAX;
    for (dc = -1; dc <= 1; dc++) begin
      for (dr = -1; dr <= 1; dr++) begin
        if (dc == 0 && dr == 0) continue;
        if (dc < 0 && out_col == 0) continue;
        if (dc > 0 && out_col + 1 >= w) continue;
        if (dr < 0 && out_row == 0) continue;
        if (dr > 0 && out_row + 1 >= h) continue;
        v = taps[(dc + 1) * 3 + (dr + 1)];
        if (cfg_mode == MODE_DILATE) begin
          if (v > acc) acc = v;
        end else begin
          if (v < acc) acc = v;
        end
      end
    end

    res.value = acc;
    if (out_col + 1 >= w && out_row + 1 >= h) begin
      res.eof = 1'b1;
      restart_frame();
    end else begin
      res.eof = 1'b0;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    morph_due.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // pixel request driver
  pix_req_t tx_item;
  bit       tx_busy = 1'b0;
  int       tx_gap  = 0;

  always @(posedge clk) begin
    if (rst) begin
      tx_busy = 1'b0;
      tx_gap  = 0;
    end else begin
      if (tx_busy && pixel_ch.ready) begin
        neighbour_min_max(tx_item);
        tx_busy = 1'b0;
        tx_gap  = $urandom_range(0, tx_gap_max);
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pixel_queue.size() > 0) begin
          tx_item = pixel_queue.pop_front();
          tx_busy = 1'b1;
        end
      end
    end
    pix_valid <= tx_busy;
    pix_value <= tx_busy ? tx_item.pixel : PIX_W'($urandom);
    pix_drain <= tx_busy ? tx_item.drain : 1'($urandom);
  end

  // ---------------------------------------------------------------------------
  // result monitor and checker
  bit         rx_rdy   = 1'b0;
  int         rx_stall = 0;
  int         rx_hold  = 0;
  morph_res_t rx_want;

  always @(posedge clk) begin
    if (rst) begin
      rx_rdy   = 1'b0;
      rx_stall = 0;
      rx_hold  = 0;
    end else begin
      if (rx_rdy && result_ch.valid) begin
        if (morph_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual value %02h eof %0b",
                   $time, result_ch.out_value, result_ch.end_of_frame);
        end else begin
          rx_want = morph_due.pop_front();
          if (result_ch.out_value !== rx_want.value) begin
            mismatches++;
            $display("%0t: out_value mismatch, expected %02h actual %02h",
                     $time, rx_want.value, result_ch.out_value);
          end
          if (result_ch.end_of_frame !== rx_want.eof) begin
            mismatches++;
            $display("%0t: end_of_frame mismatch, expected %0b actual %0b",
                     $time, rx_want.eof, result_ch.end_of_frame);
          end
        end
        rx_stall = $urandom_range(0, rx_stall_max);
      end
      if (hold_req > 0) begin
        rx_hold  = hold_req;
        hold_req = 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rx_rdy = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        rx_rdy = 1'b0;
      end else begin
        rx_rdy = 1'b1;
      end
    end
    res_ready <= rx_rdy;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || tx_busy || morph_due.size() != 0);
    // an ignored drain may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_FRAME_WIDTH: begin
        cfg_width = data[DIM_W-1:0];
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        cfg_height = data[DIM_W-1:0];
        restart_frame();
      end
      REG_MORPH_MODE: cfg_mode = data[0];
      default: ;
    endcase
  endtask

  function automatic void set_pace(int tx_max, int rx_max);
    tx_gap_max   = tx_max;
    rx_stall_max = rx_max;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return PIX_MIN;
      1: return PIX_MAX;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic int pick_pace();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 12;
    endcase
  endfunction

  function automatic void send_pixel(logic [PIX_W-1:0] v);
    pixel_queue.push_back('{pixel: v, drain: 1'b0});
  endfunction

  function automatic void send_drain();
    pixel_queue.push_back('{pixel: rand_pixel(), drain: 1'b1});
  endfunction

  // flush requests, a mix of drains and surplus pixels
  function automatic void send_flush(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) send_pixel(rand_pixel());
      else send_drain();
    end
  endfunction

  function automatic void send_frame(int w, int h, bit broken);
    int npix;
    npix = broken ? $urandom_range(1, w * h) : w * h;
    repeat (npix) begin
      if ($urandom_range(0, 15) == 0) send_drain();
      send_pixel(rand_pixel());
    end
    frame_items += npix;
    if (!broken) begin
      send_flush(w + 1);
      frame_items += w + 1;
      repeat ($urandom_range(0, 2)) send_drain();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus sequence
  logic [DIM_W-1:0] raw_w, raw_h;
  int               eff_w, eff_h;

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset configuration: 640 wide, erode
    set_pace(12, 12);
    repeat (660) send_pixel(rand_pixel());
    wait_idle();

    // directed 3x3 erode with an early drain, mixed flush and a surplus drain
    set_pace(0, 0);
    reg_write(REG_FRAME_WIDTH, 32'hFFFF_F003);
    reg_write(REG_FRAME_HEIGHT, 32'h0000_0003);
    reg_write(REG_MORPH_MODE, {31'h7FFF_FFFF, MODE_ERODE});
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h55);
    send_drain();
    send_pixel(8'hAA);
    send_pixel(8'h01);
    send_pixel(8'hFE);
    send_pixel(8'h80);
    send_pixel(8'h7F);
    send_pixel(8'hFF);
    send_drain();
    send_drain();
    send_pixel(8'h33);
    send_drain();
    send_drain();
    wait_idle();

    // 2x2 dilate
    reg_write(REG_MORPH_MODE, {31'd0, MODE_DILATE});
    reg_write(REG_FRAME_WIDTH, 32'd2);
    reg_write(REG_FRAME_HEIGHT, 32'd2);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h0F);
    send_pixel(8'hF0);
    send_pixel(8'hC3);
    send_drain();
    send_drain();
    wait_idle();

    // zero sizes read as one: a lone pixel has no neighbour
    reg_write(REG_FRAME_WIDTH, 32'd0);
    reg_write(REG_FRAME_HEIGHT, 32'd0);
    send_pixel(8'hFF);
    send_drain();
    send_drain();
    wait_idle();
    reg_write(REG_MORPH_MODE, {31'd0, MODE_ERODE});
    send_pixel(8'h00);
    send_drain();
    send_drain();
    wait_idle();

    // oversize sizes saturate, so the first line is still filling and nothing is due
    set_pace(3, 3);
    reg_write(REG_FRAME_WIDTH, 32'h0000_0FFF);
    reg_write(REG_FRAME_HEIGHT, 32'hFFFF_FFFF);
    reg_write(REG_MORPH_MODE, {31'd0, MODE_ERODE});
    repeat (40) send_pixel(rand_pixel());
    wait_idle();

    // mid-frame: unmapped write changes nothing, mode flips for the next result
    set_pace(4, 4);
    reg_write(REG_FRAME_WIDTH, 32'd8);
    reg_write(REG_FRAME_HEIGHT, 32'd6);
    repeat (30) send_pixel(rand_pixel());
    wait_idle();
    reg_write(REG_UNMAPPED, 32'h0000_0001);
    reg_write(REG_MORPH_MODE, {31'd0, MODE_DILATE});
    repeat (18) send_pixel(rand_pixel());
    send_flush(9);
    wait_idle();
    // a height write part way through restarts the frame
    repeat (20) send_pixel(rand_pixel());
    wait_idle();
    reg_write(REG_FRAME_HEIGHT, 32'd5);
    send_frame(8, 5, 1'b0);
    wait_idle();

    // receiver holds off while the sender keeps offering, so the input stalls
    reg_write(REG_FRAME_WIDTH, 32'd16);
    reg_write(REG_FRAME_HEIGHT, 32'd8);
    set_pace(0, 0);
    hold_req = HOLD_CYCLES;
    send_frame(16, 8, 1'b0);
    wait_idle();

    // random frames, a few per configuration, some cut short
    frame_items = 0;
    while (frame_items < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 15))
        0: raw_w = '0;
        1: raw_w = DIM_W'(1);
        12, 13, 14, 15: raw_w = DIM_W'($urandom_range(13, 48));
        default: raw_w = DIM_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 15))
        0: raw_h = '0;
        13, 14, 15: raw_h = DIM_W'($urandom_range(9, 16));
        default: raw_h = DIM_W'($urandom_range(1, 8));
      endcase
      eff_w = clamp_dim(raw_w, GMM_MAX_WIDTH);
      eff_h = clamp_dim(raw_h, GMM_MAX_HEIGHT);
      reg_write(REG_FRAME_WIDTH, {20'($urandom), raw_w});
      reg_write(REG_FRAME_HEIGHT, {20'($urandom), raw_h});
      reg_write(REG_MORPH_MODE, $urandom);
      if ($urandom_range(0, 7) == 0) reg_write(REG_UNMAPPED, $urandom);
      set_pace(pick_pace(), pick_pace());
      repeat ($urandom_range(1, 3)) send_frame(eff_w, eff_h, $urandom_range(0, 7) == 0);
    end
    wait_idle();

    if (mismatches == 0 && morph_due.size() == 0) begin
      $display("** gray_morph_3x3_min_max_unit: PASSED **");
    end else begin
      $display("** gray_morph_3x3_min_max_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("** gray_morph_3x3_min_max_unit: FAILED **");
    $finish;
  end

endmodule

/* gray_morph_3x3_min_max_unit.f */
rtl/gmm_pkg.sv
rtl/gmm_if.sv
rtl/gmm_regs.sv
rtl/gmm_front.sv
rtl/gmm_line_store.sv
rtl/gmm_window.sv
rtl/gray_morph_3x3_min_max_unit.sv
rtl/gmm_checker.sv
verif/tb_gray_morph_3x3_min_max_unit.sv
